### hw/rtl/rhp_pkg.sv
// Shared types, constants and helpers for the RTP header parser.
`default_nettype none

package rhp_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 65535;
  localparam int unsigned HDR_LEN_W = 19;
  localparam int unsigned FIXED_HDR_BYTES = 12;
  localparam logic [1:0] RTP_VERSION = 2'd2;
  localparam int unsigned CC_LSB = 0;
  localparam int unsigned EXT_BIT = 4;
  localparam int unsigned PAD_BIT = 5;
  localparam int unsigned VER_LSB = 6;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_LEN_VER       = 3'd1,
    ST_CSRC_SHORT    = 3'd2,
    ST_EXT_HDR_SHORT = 3'd3,
    ST_EXT_BODY_SHORT = 3'd4,
    ST_PADDING       = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0]           first_hdr;
    logic                 marker;
    logic [15:0]          seq;
    logic [31:0]          ts;
    logic [7:0]           ext_high;
    logic [HDR_LEN_W-1:0] hdr_len;
  } hdr_state_t;

  typedef struct packed {
    status_t     status;
    logic        marker;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [15:0] offset;
    logic [15:0] paylen;
  } result_t;

  localparam hdr_state_t STATE_RESET = '{
    first_hdr: 8'd0,
    marker:    1'b0,
    seq:       16'd0,
    ts:        32'd0,
    ext_high:  8'd0,
    hdr_len:   HDR_LEN_W'(FIXED_HDR_BYTES)
  };

  // End of the CSRC list: fixed header plus four bytes per CSRC entry.
  function automatic logic [HDR_LEN_W-1:0] csrc_end(input logic [7:0] first_hdr);
    return HDR_LEN_W'(FIXED_HDR_BYTES)
         + {{(HDR_LEN_W-6){1'b0}}, first_hdr[CC_LSB +: 4], 2'b00};
  endfunction

endpackage

`default_nettype wire

### hw/rtl/rhp_field_capture.sv
// Per-packet header field capture, byte counter and header length tracking.
`default_nettype none

module rhp_field_capture #(
  parameter int unsigned MAX_PACKET_BYTES = rhp_pkg::MAX_PACKET_BYTES_DEF,
  parameter int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 2)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire logic [7:0]         byte_value,
  input  wire logic               last_byte,
  output rhp_pkg::hdr_state_t     state_next,
  output logic [CNT_W-1:0]        count_next
);
  import rhp_pkg::*;

  localparam logic [CNT_W-1:0] COUNT_SAT = CNT_W'(MAX_PACKET_BYTES + 1);

  hdr_state_t           state;
  logic [CNT_W-1:0]     byte_count;
  logic [HDR_LEN_W-1:0] idx;
  logic [HDR_LEN_W-1:0] base;
  logic                 ext;

  always_comb begin
    idx = HDR_LEN_W'(byte_count);
    state_next = state;

    if (byte_count == '0) begin
      state_next.first_hdr = byte_value;
      state_next.hdr_len = csrc_end(byte_value);
    end else if (byte_count == CNT_W'(1)) begin
      state_next.marker = byte_value[7];
    end else if (byte_count == CNT_W'(2) || byte_count == CNT_W'(3)) begin
      state_next.seq = {state.seq[7:0], byte_value};
    end else if (byte_count >= CNT_W'(4) && byte_count <= CNT_W'(7)) begin
      state_next.ts = {state.ts[23:0], byte_value};
    end

    // The extension word count sits two and three bytes past the CSRC list.
    base = csrc_end(state_next.first_hdr);
    ext = state_next.first_hdr[EXT_BIT];
    if (ext && idx == base + HDR_LEN_W'(2)) begin
      state_next.ext_high = byte_value;
    end else if (ext && idx == base + HDR_LEN_W'(3)) begin
      state_next.hdr_len = base + HDR_LEN_W'(4) + {1'b0, state.ext_high, byte_value, 2'b00};
    end

    count_next = (byte_count < COUNT_SAT) ? byte_count + CNT_W'(1) : byte_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
      byte_count <= '0;
    end else if (advance) begin
      if (last_byte) begin
        state <= STATE_RESET;
        byte_count <= '0;
      end else begin
        state <= state_next;
        byte_count <= count_next;
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    byte_count <= COUNT_SAT)
    else $error("byte count passed its saturation value");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && last_byte |=> byte_count == '0 && state.hdr_len == HDR_LEN_W'(FIXED_HDR_BYTES))
    else $error("packet state not cleared after the final word");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    advance && !last_byte && byte_count < COUNT_SAT
      |=> byte_count == $past(byte_count) + CNT_W'(1))
    else $error("byte count did not step by one");

endmodule

`default_nettype wire

### hw/rtl/rhp_status_eval.sv
// Final-word checks: status, payload offset and payload length without padding.
`default_nettype none

module rhp_status_eval #(
  parameter int unsigned MAX_PACKET_BYTES = rhp_pkg::MAX_PACKET_BYTES_DEF,
  parameter int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 2)
) (
  input  wire rhp_pkg::hdr_state_t state_next,
  input  wire logic [CNT_W-1:0] count_next,
  input  wire logic [7:0]       byte_value,
  output rhp_pkg::result_t      result
);
  import rhp_pkg::*;

  logic [HDR_LEN_W-1:0] len;
  logic [HDR_LEN_W-1:0] base;
  logic [HDR_LEN_W-1:0] pay_full;
  logic                 ext;
  status_t              status;
  logic [15:0]          paylen;

  always_comb begin
    len = HDR_LEN_W'(count_next);
    base = csrc_end(state_next.first_hdr);
    ext = state_next.first_hdr[EXT_BIT];
    pay_full = len - state_next.hdr_len;
    status = ST_OK;
    paylen = '0;

    if (len > HDR_LEN_W'(MAX_PACKET_BYTES) || len < HDR_LEN_W'(FIXED_HDR_BYTES)
        || state_next.first_hdr[VER_LSB +: 2] != RTP_VERSION) begin
      status = ST_LEN_VER;
    end else if (len < base) begin
      status = ST_CSRC_SHORT;
    end else if (ext && len < base + HDR_LEN_W'(4)) begin
      status = ST_EXT_HDR_SHORT;
    end else if (len < state_next.hdr_len) begin
      status = ST_EXT_BODY_SHORT;
    end else begin
      paylen = pay_full[15:0];
      // The final byte of a padded packet holds the padding count.
      if (state_next.first_hdr[PAD_BIT] && pay_full != '0) begin
        if (byte_value == 8'd0 || HDR_LEN_W'(byte_value) > pay_full) begin
          status = ST_PADDING;
        end else begin
          paylen = pay_full[15:0] - 16'(byte_value);
        end
      end
    end

    result = '0;
    result.status = status;
    if (status == ST_OK) begin
      result.marker = state_next.marker;
      result.seq = state_next.seq;
      result.ts = state_next.ts;
      result.offset = state_next.hdr_len[15:0];
      result.paylen = paylen;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rtp_header_parser_core.sv
// Top level of the RTP fixed-header parser: input register, result register and handshakes.
`default_nettype none

// RTP fixed-header parser. Takes one packet byte per word, with last_byte set on
// the final byte, and gives one result word per packet on the cycle after its final
// byte leaves the input register: status, and for an accepted packet the marker,
// sequence number, timestamp, payload offset and payload length with padding
// removed (all zero on a rejection). Throughput is one byte per clock when the input
// side is not stalled. When the result register is free, the final byte passes
// through the input register and then the result register before out_valid rises;
// the input register and the result register sit around a single pass of header logic.
// The input side stalls only while a result is held and the final byte of the next
// packet is waiting.
// Packets longer than MAX_PACKET_BYTES are rejected with the length/version status.
module rtp_header_parser_core #(
  parameter int unsigned MAX_PACKET_BYTES = rhp_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  byte_value,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic             marker,
  output logic [15:0]      sequence_number,
  output logic [31:0]      rtp_timestamp,
  output logic [15:0]      payload_offset,
  output logic [15:0]      payload_length
);
  import rhp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 2);

  logic             hold_valid;
  logic [7:0]       hold_byte;
  logic             hold_last;
  logic             advance;
  logic             load_result;
  hdr_state_t       state_next;
  logic [CNT_W-1:0] count_next;
  result_t          result_next;
  result_t          result;

  // Only a final byte needs the result register free to move on.
  assign advance = hold_valid && (!hold_last || !out_valid || out_ready);
  assign load_result = advance && hold_last;
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= byte_value;
      hold_last <= last_byte;
    end
  end

  rhp_field_capture #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
    .CNT_W(CNT_W)
  ) u_capture (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .byte_value(hold_byte),
    .last_byte(hold_last),
    .state_next(state_next),
    .count_next(count_next)
  );

  rhp_status_eval #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
    .CNT_W(CNT_W)
  ) u_eval (
    .state_next(state_next),
    .count_next(count_next),
    .byte_value(hold_byte),
    .result(result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result <= result_next;
    end
  end

  assign status = result.status;
  assign marker = result.marker;
  assign sequence_number = result.seq;
  assign rtp_timestamp = result.ts;
  assign payload_offset = result.offset;
  assign payload_length = result.paylen;

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !marker && sequence_number == '0
      && rtp_timestamp == '0 && payload_offset == '0 && payload_length == '0)
    else $error("rejected packet carries nonzero fields");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(hold_valid && hold_last))
    else $error("result appeared without a final byte");

endmodule

`default_nettype wire
